[src/ple_pkg.sv]
// ple_pkg: request codes, status codes, datapath operation codes and the
// command structs shared by the list controller and the list datapath.
// No dependencies.
package ple_pkg;

    // request codes
    localparam logic [3:0] REQ_INS_HEAD = 4'd0;
    localparam logic [3:0] REQ_INS_TAIL = 4'd1;
    localparam logic [3:0] REQ_INS_AT   = 4'd2;
    localparam logic [3:0] REQ_DEL_HEAD = 4'd3;
    localparam logic [3:0] REQ_DEL_TAIL = 4'd4;
    localparam logic [3:0] REQ_DEL_AT   = 4'd5;
    localparam logic [3:0] REQ_SHOW     = 4'd6;
    localparam logic [3:0] REQ_SIZE     = 4'd7;
    localparam logic [3:0] REQ_CLEAR    = 4'd8;
    localparam logic [3:0] REQ_REVERSE  = 4'd9;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // datapath operations
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_INS  = 3'd1;
    localparam logic [2:0] OP_DEL  = 3'd2;
    localparam logic [2:0] OP_ROT  = 3'd3;
    localparam logic [2:0] OP_CLR  = 3'd4;

    // most results one show request emits
    localparam int MAX_RESULTS = 16;
    // largest value the element count field carries
    localparam int COUNT_FIELD_MAX = 31;

    // list operation for this cycle; pos is the insert/delete position
    // or the upper end of the rotated range
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] pos;
    } t_dp_cmd;

    // result register load
    typedef struct packed {
        logic strobe;
        logic present;
        logic last;
    } t_res_cmd;

endpackage

[src/ple_datapath.sv]
// ple_datapath: element register array, element count and result register.
// Insert/delete shift the array; rotate moves the head entry
// to a given index. Depends on ple_pkg.
module ple_datapath
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  t_res_cmd             i_res,
    input  logic signed [31:0]   i_value,
    output logic [CW-1:0]        o_count,
    output logic                 o_valid,
    output logic signed [31:0]   o_elem_value,
    output logic                 o_elem_present,
    output logic                 o_last_of_run,
    output logic [4:0]           o_element_count,
    output logic [1:0]           o_status
);

    logic [31:0]   r_store [CAPACITY];
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    w_status;
    logic          w_full;
    logic          w_del_ok;
    logic [CW-1:0] w_ins_pos;
    logic [CW-1:0] w_arg;

    // position decode
    always_comb begin
        w_full    = (32'(r_count) >= CAPACITY);
        w_del_ok  = ({1'b0, i_cmd.pos} < 9'(r_count));
        w_arg     = CW'(i_cmd.pos);
        w_ins_pos = ({1'b0, i_cmd.pos} > 9'(r_count)) ? r_count : w_arg;
    end

    // count update and status
    always_comb begin
        n_count  = r_count;
        w_status = ST_OK;
        case (i_cmd.op)
            OP_INS: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_DEL: begin
                if (w_del_ok) begin
                    n_count = r_count - 1'b1;
                end else begin
                    w_status = ST_NONE;
                end
            end
            OP_CLR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // per-entry shift logic
    for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
        localparam logic [CW-1:0] IDX = CW'(g);
        logic [31:0] w_prev, w_next, n_elem;
        logic        w_we;

        if (g > 0) begin : g_prev
            assign w_prev = r_store[g-1];
        end else begin : g_prev_none
            assign w_prev = r_store[g];
        end

        if (g < CAPACITY - 1) begin : g_next
            assign w_next = r_store[g+1];
        end else begin : g_next_none
            assign w_next = r_store[g];
        end

        always_comb begin
            n_elem = r_store[g];
            w_we   = 1'b0;
            case (i_cmd.op)
                OP_INS: begin
                    if (!w_full && IDX == w_ins_pos) begin
                        n_elem = i_value;
                        w_we   = 1'b1;
                    end else if (!w_full && IDX > w_ins_pos) begin
                        n_elem = w_prev;
                        w_we   = 1'b1;
                    end
                end
                OP_DEL: begin
                    if (w_del_ok && IDX >= w_arg) begin
                        n_elem = w_next;
                        w_we   = 1'b1;
                    end
                end
                OP_ROT: begin
                    if (IDX < w_arg) begin
                        n_elem = w_next;
                        w_we   = 1'b1;
                    end else if (IDX == w_arg) begin
                        n_elem = r_store[0];
                        w_we   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_store[g] <= n_elem;
            end
        end
    end

    assign o_count = r_count;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_res.strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.strobe) begin
            o_elem_value   <= i_res.present ? r_store[0] : '0;
            o_elem_present <= i_res.present;
            o_last_of_run  <= i_res.last;
            o_status       <= w_status;
            o_element_count <= (32'(n_count) > COUNT_FIELD_MAX) ?
                               5'(COUNT_FIELD_MAX) : 5'(n_count);
        end
    end

endmodule

[src/ple_ctrl.sv]
// ple_ctrl: request decoder and sequencer for show and reverse.
// Drives datapath commands and result loads. Depends on ple_pkg.
module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [3:0]    i_req_type,
    input  logic [7:0]    i_position,
    input  logic [CW-1:0] i_count,
    output logic          o_busy,
    output t_dp_cmd       o_cmd,
    output t_res_cmd      o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SHOW = 2'd1;
    localparam logic [1:0] S_REV  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_step, n_step;
    logic [7:0]    w_tail;
    int            w_show_n;

    always_comb begin
        w_tail   = 8'(i_count - 1'b1);
        w_show_n = (32'(i_count) > MAX_RESULTS) ? MAX_RESULTS : 32'(i_count);
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '{op: OP_NONE, pos: 8'd0};
        o_res   = '{strobe: 1'b0, present: 1'b0, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_res.strobe = 1'b1;
                    case (i_req_type)
                        REQ_INS_HEAD: o_cmd = '{op: OP_INS, pos: 8'd0};
                        REQ_INS_TAIL: o_cmd = '{op: OP_INS, pos: 8'(i_count)};
                        REQ_INS_AT:   o_cmd = '{op: OP_INS, pos: i_position};
                        REQ_DEL_HEAD: o_cmd = '{op: OP_DEL, pos: 8'd0};
                        REQ_DEL_TAIL: begin
                            o_cmd = '{op: OP_DEL, pos: (i_count == '0) ? 8'd0 : w_tail};
                        end
                        REQ_DEL_AT:   o_cmd = '{op: OP_DEL, pos: i_position};
                        REQ_SHOW: begin
                            // empty list gives one empty result
                            if (i_count != '0) begin
                                o_res.strobe = 1'b0;
                                n_state      = S_SHOW;
                                n_step       = '0;
                            end
                        end
                        REQ_CLEAR:    o_cmd = '{op: OP_CLR, pos: 8'd0};
                        REQ_REVERSE: begin
                            // result now, reorder in the following cycles
                            if (32'(i_count) >= 2) begin
                                n_state = S_REV;
                                n_step  = i_count - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHOW: begin
                // emit head, rotate it to the tail
                o_cmd         = '{op: OP_ROT, pos: w_tail};
                o_res.strobe  = (32'(r_step) < MAX_RESULTS);
                o_res.present = 1'b1;
                o_res.last    = (32'(r_step) + 1 == w_show_n);
                if (32'(r_step) + 1 == 32'(i_count)) begin
                    n_state = S_IDLE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_REV: begin
                // move head into place at the shrinking end
                o_cmd = '{op: OP_ROT, pos: 8'(r_step)};
                if (32'(r_step) == 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[src/positional_list_engine.sv]
// positional_list_engine: ordered list of signed 32-bit values in a register array.
// Each result appears in the cycle after it is produced; insert, delete, size, clear
// leave the block idle, so such requests can be accepted every cycle.
// Show is busy while it rotates each element to the tail, one result per cycle.
// Reverse gives its result next cycle, then rotates while busy, one rotation a cycle.
// Synchronous active-low reset empties the list; the receiver cannot stall.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [3:0]         i_req_type,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic signed [31:0] o_elem_value,
    output logic               o_elem_present,
    output logic               o_last_of_run,
    output logic [4:0]         o_element_count,
    output logic [1:0]         o_status
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_dp_cmd       w_cmd;
    t_res_cmd      w_res;
    logic [CW-1:0] w_count;
    logic          w_busy;

    // controller
    ple_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_position (i_position),
        .i_count    (w_count),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd),
        .o_res      (w_res)
    );

    // list storage and result register
    ple_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_res           (w_res),
        .i_value         (i_value),
        .o_count         (w_count),
        .o_valid         (o_valid),
        .o_elem_value    (o_elem_value),
        .o_elem_present  (o_elem_present),
        .o_last_of_run   (o_last_of_run),
        .o_element_count (o_element_count),
        .o_status        (o_status)
    );

    assign o_busy = w_busy;

endmodule

[src/ple_checker.sv]
// ple_checker: port-level checks for positional_list_engine, bound to the top level.
// Depends on ple_pkg.
module ple_checker
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic [3:0]         i_req_type,
    input logic               o_valid,
    input logic signed [31:0] o_elem_value,
    input logic               o_elem_present,
    input logic               o_last_of_run,
    input logic [4:0]         o_element_count,
    input logic [1:0]         o_status
);

    // reset leaves the block idle with no result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_busy)
        else $error("block not idle after reset");

    // any request other than show answers with one final result next cycle
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_req_type != REQ_SHOW |=> o_valid && o_last_of_run)
        else $error("missing single result");

    // shown elements carry ok status
    a_show_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_elem_present |-> o_status == ST_OK)
        else $error("element result with error status");

    // results without an element carry zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_elem_present |-> o_elem_value == 32'sd0)
        else $error("non-element result with nonzero value");

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_element_count) <= CAPACITY)
        else $error("element count beyond capacity");

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

[verif/tb_positional_list_engine.sv]
// tb_positional_list_engine: self-checking bench for the positional list engine.
// Depends on ple_pkg and positional_list_engine; a shadow list predicts every result.
`timescale 1ns / 100ps

module tb_positional_list_engine;
    import ple_pkg::*;

    localparam int          LIST_DEPTH       = 16;
    localparam int          RANDOM_REQUESTS  = 450;
    localparam int          CALM_TAIL        = 60;
    localparam int          CYCLE_LIMIT      = 200000;
    localparam logic [3:0]  REQ_FIRST_UNUSED = 4'd10;
    localparam logic [3:0]  REQ_LAST_CODE    = 4'd15;

    typedef struct {
        logic signed [31:0] elem_value;
        logic               present;
        logic               last;
        logic [4:0]         count;
        logic [1:0]         status;
    } list_result_t;

    // shadow list plus the queue of results it predicts
    class list_ledger;
        logic signed [31:0] shadow_elems [LIST_DEPTH];
        int                 shadow_count;
        list_result_t       awaited_results [$];
        int                 requests;
        int                 results_seen;
        int                 shown_elems;
        int                 dropped_inserts;
        int                 empty_removals;
        int                 mismatches;

        function new();
            shadow_count    = 0;
            requests        = 0;
            results_seen    = 0;
            shown_elems     = 0;
            dropped_inserts = 0;
            empty_removals  = 0;
            mismatches      = 0;
        endfunction

        function logic [1:0] insert_elem(int pos, logic signed [31:0] val);
            if (shadow_count >= LIST_DEPTH) begin
                dropped_inserts++;
                return ST_FULL;
            end
            if (pos > shadow_count)
                pos = shadow_count;
            for (int i = shadow_count; i > pos; i--)
                shadow_elems[i] = shadow_elems[i - 1];
            shadow_elems[pos] = val;
            shadow_count++;
            return ST_OK;
        endfunction

        function logic [1:0] remove_elem(int pos);
            if (pos >= shadow_count) begin
                empty_removals++;
                return ST_NONE;
            end
            for (int i = pos; i + 1 < shadow_count; i++)
                shadow_elems[i] = shadow_elems[i + 1];
            shadow_count--;
            return ST_OK;
        endfunction

        function void push_result(logic signed [31:0] v, logic p, logic l, logic [1:0] s);
            list_result_t r;
            r.elem_value = v;
            r.present    = p;
            r.last       = l;
            r.count      = (shadow_count > COUNT_FIELD_MAX) ? 5'(COUNT_FIELD_MAX)
                                                            : 5'(shadow_count);
            r.status     = s;
            awaited_results.push_back(r);
        endfunction

        // apply one accepted request and queue what it should produce
        function void note_request(logic [3:0] req, logic [7:0] pos, logic signed [31:0] val);
            logic [1:0]         st;
            int                 n;
            logic signed [31:0] tmp;
            st = ST_OK;
            requests++;
            case (req)
                REQ_INS_HEAD: st = insert_elem(0, val);
                REQ_INS_TAIL: st = insert_elem(shadow_count, val);
                REQ_INS_AT:   st = insert_elem(int'(pos), val);
                REQ_DEL_HEAD: st = remove_elem(0);
                REQ_DEL_TAIL: begin
                    if (shadow_count == 0) begin
                        empty_removals++;
                        st = ST_NONE;
                    end else begin
                        st = remove_elem(shadow_count - 1);
                    end
                end
                REQ_DEL_AT:   st = remove_elem(int'(pos));
                REQ_SHOW: begin
                    if (shadow_count == 0) begin
                        push_result('0, 1'b0, 1'b1, ST_OK);
                    end else begin
                        n = (shadow_count > MAX_RESULTS) ? MAX_RESULTS : shadow_count;
                        for (int i = 0; i < n; i++)
                            push_result(shadow_elems[i], 1'b1, i + 1 == n, ST_OK);
                        shown_elems += n;
                    end
                    return;
                end
                REQ_SIZE:  ;
                REQ_CLEAR: shadow_count = 0;
                REQ_REVERSE: begin
                    for (int i = 0; i < shadow_count / 2; i++) begin
                        tmp = shadow_elems[i];
                        shadow_elems[i] = shadow_elems[shadow_count - 1 - i];
                        shadow_elems[shadow_count - 1 - i] = tmp;
                    end
                end
                default: ;
            endcase
            push_result('0, 1'b0, 1'b1, st);
        endfunction

        task flag_mismatch(string what, logic signed [31:0] want, logic signed [31:0] got);
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        endtask

        // compare one strobed result against the oldest prediction
        task check_result(logic signed [31:0] v, logic p, logic l, logic [4:0] c, logic [1:0] s);
            list_result_t want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                flag_mismatch("result with nothing pending", 0, v);
            end else begin
                want = awaited_results.pop_front();
                if (v !== want.elem_value) flag_mismatch("elem_value", want.elem_value, v);
                if (p !== want.present)    flag_mismatch("elem_present", want.present, p);
                if (l !== want.last)       flag_mismatch("last_of_run", want.last, l);
                if (c !== want.count)      flag_mismatch("element_count", want.count, c);
                if (s !== want.status)     flag_mismatch("status", want.status, s);
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [3:0]         i_req_type;
    logic [7:0]         i_position;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic signed [31:0] o_elem_value;
    logic               o_elem_present;
    logic               o_last_of_run;
    logic [4:0]         o_element_count;
    logic [1:0]         o_status;

    list_ledger ledger;
    int         cycle_count;

    positional_list_engine #(
        .CAPACITY(LIST_DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_elem_value   (o_elem_value),
        .o_elem_present (o_elem_present),
        .o_last_of_run  (o_last_of_run),
        .o_element_count(o_element_count),
        .o_status       (o_status)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result monitor, samples pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            ledger.check_result(o_elem_value, o_elem_present, o_last_of_run,
                                o_element_count, o_status);
    end

    // present one request and hold it until the block takes it
    task automatic send_req(input logic [3:0] req, input logic [7:0] pos,
                            input logic signed [31:0] val);
        i_start    <= 1'b1;
        i_req_type <= req;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        ledger.note_request(req, pos, val);
    endtask

    // drop start for a while, with junk on the request fields
    task automatic idle_gap(input int cycles);
        i_start    <= 1'b0;
        i_req_type <= 4'($urandom);
        i_position <= 8'($urandom);
        i_value    <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // mostly near the live range, sometimes anywhere in the field
    function automatic logic [7:0] pick_pos(int held);
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, held + 1));
    endfunction

    initial begin
        logic [3:0] req;
        int         roll;
        bit         filling;
        bit         gappy;

        ledger     = new();
        i_rst_n    <= 1'b0;
        i_start    <= 1'b0;
        i_req_type <= '0;
        i_position <= '0;
        i_value    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corners
        send_req(REQ_SHOW, 8'h00, 0);
        send_req(REQ_DEL_HEAD, 8'h00, 0);
        send_req(REQ_DEL_TAIL, 8'h00, 0);
        send_req(REQ_DEL_AT, 8'hFF, 0);
        send_req(REQ_SIZE, 8'h00, 0);
        send_req(REQ_LAST_CODE, 8'hFF, -1);

        // value extremes, insert past the end appends
        send_req(REQ_INS_HEAD, 8'h00, 32'sh7FFF_FFFF);
        send_req(REQ_INS_TAIL, 8'hFF, 32'sh8000_0000);
        send_req(REQ_INS_AT, 8'hFF, -1);
        send_req(REQ_INS_AT, 8'h00, 0);
        send_req(REQ_REVERSE, 8'h00, 0);

        // fill to capacity, then push against the full list
        while (ledger.shadow_count < LIST_DEPTH)
            send_req(REQ_INS_AT, 8'($urandom_range(0, ledger.shadow_count)), $urandom);
        send_req(REQ_INS_TAIL, 8'h00, 32'sh1234_5678);
        send_req(REQ_SHOW, 8'h00, 0);
        send_req(REQ_DEL_AT, 8'd16, 0);
        send_req(REQ_REVERSE, 8'h00, 0);
        send_req(REQ_DEL_AT, 8'd7, 0);
        send_req(REQ_CLEAR, 8'h00, 0);

        // random traffic, drifting between full and empty
        filling = 1'b1;
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (ledger.shadow_count >= LIST_DEPTH) filling = 1'b0;
            if (ledger.shadow_count == 0)          filling = 1'b1;
            gappy = ((k / 40) % 2) == 0;
            if (gappy && k < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 15));

            roll = $urandom_range(0, 99);
            if (roll < 3)
                req = 4'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE));
            else if (roll < 5)
                req = REQ_CLEAR;
            else if (roll < 10)
                req = REQ_SIZE;
            else if (roll < 20)
                req = REQ_SHOW;
            else if (roll < 27)
                req = REQ_REVERSE;
            else if ((roll < 80) == filling) begin
                case ($urandom_range(0, 2))
                    0:       req = REQ_INS_HEAD;
                    1:       req = REQ_INS_TAIL;
                    default: req = REQ_INS_AT;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       req = REQ_DEL_HEAD;
                    1:       req = REQ_DEL_TAIL;
                    default: req = REQ_DEL_AT;
                endcase
            end
            send_req(req, pick_pos(ledger.shadow_count), pick_value());
        end

        // drain and watch for stray results
        i_start <= 1'b0;
        while (ledger.awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * MAX_RESULTS) @(posedge i_clk);

        $display("covered %0d requests and %0d results: %0d listed elements,",
                 ledger.requests, ledger.results_seen, ledger.shown_elems);
        $display("%0d inserts dropped on a full list, %0d removals that found nothing",
                 ledger.dropped_inserts, ledger.empty_removals);
        if (ledger.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
src/ple_pkg.sv
src/ple_datapath.sv
src/ple_ctrl.sv
src/positional_list_engine.sv
src/ple_checker.sv
verif/tb_positional_list_engine.sv
